// ===== sv/hcsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hcsp_pkg;

	localparam int MAX_DIGITS  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W       = 5;

	localparam logic [7:0]       HASH_CHAR = 8'h23;
	localparam logic [POS_W-1:0] POS_MAX   = 5'd31;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_HASH   = 3'd1,
		ST_BAD_COUNT = 3'd2,
		ST_NON_HEX   = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	// one classified character as it travels from front to back
	typedef struct packed {
		logic [3:0] nibble;
		logic       is_hex;
		logic       is_hash;
		logic       last;
	} char_class_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic        valid;
		char_class_t item;
	} queue_head_t;

endpackage
`default_nettype wire

// ===== sv/hcsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hcsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_spec;

	modport source (output valid, output char_code, output end_of_spec, input ready);
	modport sink (input valid, input char_code, input end_of_spec, output ready);
endinterface

interface hcsp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic [15:0] alpha;
	logic        had_alpha;

	modport source (
		output valid, output status, output red, output green, output blue,
		output alpha, output had_alpha, input ready
	);
	modport sink (
		input valid, input status, input red, input green, input blue,
		input alpha, input had_alpha, output ready
	);
endinterface
`default_nettype wire

// ===== sv/hcsp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcsp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	hcsp_char_if.sink            char_in,
	output hcsp_pkg::queue_head_t head,
	input  wire                  pop
);

	hcsp_pkg::char_class_t                   entry_q [hcsp_pkg::QUEUE_DEPTH];
	logic [hcsp_pkg::QPTR_W-1:0]             wr_ptr_q;
	logic [hcsp_pkg::QPTR_W-1:0]             rd_ptr_q;
	logic [hcsp_pkg::QCNT_W-1:0]             cnt_q;
	hcsp_pkg::char_class_t                   cls;
	logic                                    push;
	logic                                    do_pop;
	logic [7:0]                              ch;

	assign ch = char_in.char_code;

	always_comb begin
		cls.nibble  = 4'd0;
		cls.is_hex  = 1'b0;
		cls.is_hash = (ch == hcsp_pkg::HASH_CHAR);
		cls.last    = char_in.end_of_spec;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			cls.nibble = 4'(ch - 8'h30);
			cls.is_hex = 1'b1;
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			cls.nibble = 4'(ch - 8'h57);
			cls.is_hex = 1'b1;
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			cls.nibble = 4'(ch - 8'h37);
			cls.is_hex = 1'b1;
		end
	end

	assign char_in.ready = (cnt_q != hcsp_pkg::QCNT_W'(hcsp_pkg::QUEUE_DEPTH));
	assign push          = char_in.valid && char_in.ready;
	assign do_pop        = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/hcsp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcsp_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire hcsp_pkg::queue_head_t head,
	output logic                       pop,
	hcsp_result_if.source              result_out
);

	localparam int MAX_DIGITS = hcsp_pkg::MAX_DIGITS;
	localparam int IW         = $clog2(MAX_DIGITS);
	localparam int POS_W      = hcsp_pkg::POS_W;

	logic [3:0]       store_q [MAX_DIGITS];
	logic [POS_W-1:0] pos_q;
	logic             hash_q;
	logic             bad_q;

	logic             pend_s1;
	logic [2:0]       per_s1;
	logic             alpha_s1;
	hcsp_pkg::status_t status_s1;

	logic             out_v_q;
	logic [2:0]       status_q;
	logic [15:0]      red_q, green_q, blue_q, alpha_q;
	logic             had_alpha_q;

	logic             take, s1_move;
	hcsp_pkg::char_class_t it;
	logic [POS_W-1:0] idx_w, pos_inc, count;
	logic             hash_n, bad_n;
	logic [2:0]       per_n;
	logic             alpha_n;
	hcsp_pkg::status_t status_n;
	logic [15:0]      red_w, green_w, blue_w, alpha_w;

	assign it      = head.item;
	assign s1_move = pend_s1 && (!out_v_q || result_out.ready);
	assign take    = head.valid && (!pend_s1 || s1_move);
	assign pop     = take;

	assign idx_w   = pos_q - 1'b1;
	assign pos_inc = (pos_q == hcsp_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
	assign count   = pos_inc - 1'b1;
	assign hash_n  = (pos_q == '0) ? it.is_hash : hash_q;
	assign bad_n   = bad_q || ((pos_q != '0) && !it.is_hex);

	// digits per channel; zero marks a length with no colour form
	always_comb begin
		per_n   = 3'd0;
		alpha_n = 1'b0;
		case (count)
			5'd3:    per_n = 3'd1;
			5'd6:    per_n = 3'd2;
			5'd9:    per_n = 3'd3;
			5'd12:   per_n = 3'd4;
			5'd4:    begin per_n = 3'd1; alpha_n = 1'b1; end
			5'd8:    begin per_n = 3'd2; alpha_n = 1'b1; end
			5'd16:   begin per_n = 3'd4; alpha_n = 1'b1; end
			default: per_n = 3'd0;
		endcase
		if (!hash_n) begin
			status_n = hcsp_pkg::ST_NO_HASH;
		end else if (count > POS_W'(MAX_DIGITS)) begin
			status_n = hcsp_pkg::ST_TOO_LONG;
		end else if (per_n == 3'd0) begin
			status_n = hcsp_pkg::ST_BAD_COUNT;
		end else if (bad_n) begin
			status_n = hcsp_pkg::ST_NON_HEX;
		end else begin
			status_n = hcsp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pos_q != '0 && idx_w < POS_W'(MAX_DIGITS)) begin
			store_q[idx_w[IW-1:0]] <= it.is_hex ? it.nibble : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hash_q  <= 1'b0;
			bad_q   <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (it.last) begin
					pos_q  <= '0;
					hash_q <= 1'b0;
					bad_q  <= 1'b0;
				end else begin
					pos_q  <= pos_inc;
					hash_q <= hash_n;
					bad_q  <= bad_n;
				end
			end
			if (take && it.last) begin
				pend_s1 <= 1'b1;
			end else if (s1_move) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && it.last) begin
			per_s1    <= per_n;
			alpha_s1  <= alpha_n;
			status_s1 <= status_n;
		end
	end

	// channel expansion: every form reads the store at fixed places
	always_comb begin
		case (per_s1)
			3'd1: begin
				red_w   = {4{store_q[0]}};
				green_w = {4{store_q[1]}};
				blue_w  = {4{store_q[2]}};
				alpha_w = {4{store_q[3]}};
			end
			3'd2: begin
				red_w   = {2{store_q[0], store_q[1]}};
				green_w = {2{store_q[2], store_q[3]}};
				blue_w  = {2{store_q[4], store_q[5]}};
				alpha_w = {2{store_q[6], store_q[7]}};
			end
			3'd3: begin
				red_w   = {store_q[0], store_q[1], store_q[2], store_q[0]};
				green_w = {store_q[3], store_q[4], store_q[5], store_q[3]};
				blue_w  = {store_q[6], store_q[7], store_q[8], store_q[6]};
				alpha_w = {store_q[9], store_q[10], store_q[11], store_q[9]};
			end
			3'd4: begin
				red_w   = {store_q[0], store_q[1], store_q[2], store_q[3]};
				green_w = {store_q[4], store_q[5], store_q[6], store_q[7]};
				blue_w  = {store_q[8], store_q[9], store_q[10], store_q[11]};
				alpha_w = {store_q[12], store_q[13], store_q[14], store_q[15]};
			end
			default: begin
				red_w   = 16'd0;
				green_w = 16'd0;
				blue_w  = 16'd0;
				alpha_w = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			status_q <= status_s1;
			if (status_s1 == hcsp_pkg::ST_OK) begin
				red_q       <= red_w;
				green_q     <= green_w;
				blue_q      <= blue_w;
				alpha_q     <= alpha_s1 ? alpha_w : 16'hFFFF;
				had_alpha_q <= alpha_s1;
			end else begin
				red_q       <= 16'd0;
				green_q     <= 16'd0;
				blue_q      <= 16'd0;
				alpha_q     <= 16'd0;
				had_alpha_q <= 1'b0;
			end
		end
	end

	assign result_out.valid     = out_v_q;
	assign result_out.status    = status_q;
	assign result_out.red       = red_q;
	assign result_out.green     = green_q;
	assign result_out.blue      = blue_q;
	assign result_out.alpha     = alpha_q;
	assign result_out.had_alpha = had_alpha_q;

`ifndef ASSERT_OFF
	a_stall_holds_intake: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && out_v_q && !result_out.ready |-> !take)
		else $error("char taken while pending result is blocked");

	a_spec_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && it.last |=> pos_q == '0 && !hash_q && !bad_q && pend_s1)
		else $error("spec state not cleared after last char");

	a_no_bad_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> !bad_q)
		else $error("bad digit flag set before any digit");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q != hcsp_pkg::ST_OK |->
		red_q == 16'd0 && alpha_q == 16'd0 && !had_alpha_q)
		else $error("failed result carries colour data");

	a_result_follows_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(pend_s1))
		else $error("result issued without pending spec");
`endif

endmodule
`default_nettype wire

// ===== sv/hex_color_string_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Hex colour spec parser. Characters of a spec ('#' then hex digits) arrive one per beat
// on char_in, the final one flagged by end_of_spec; one result beat follows on result_out
// with status and the four channels widened to 16 bits (3/6/9/12 digits give RGB with
// alpha 0xFFFF, 4/8/16 give RGBA). A character is taken every cycle while char_in.ready is
// high: a two-entry queue after the classifier feeds the back end, which updates the digit
// store and counters for each character it takes. On the last character the length and
// status are registered in a holding stage, from which the channels are expanded into
// the output register. If a finished result is not taken, the back end still takes the
// next spec up to its last character, whose status waits in the holding stage; only then
// does it stop, and the queue absorbs two more before char_in.ready falls.
module hex_color_string_parser_unit (
	input  wire           clk,
	input  wire           arst_n,
	hcsp_char_if.sink     char_in,
	hcsp_result_if.source result_out
);

	hcsp_pkg::queue_head_t head;
	logic                  pop;

	hcsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.head    (head),
		.pop     (pop)
	);

	hcsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule
`default_nettype wire
